// ===== design/wwbs_pkg.sv =====
package wwbs_pkg;

    localparam int MAX_ROWS  = 1024;
    localparam int MAX_COLS  = 1024;
    localparam int MAX_KSIZE = 15;

    // Field widths fixed by the interface
    localparam int COORD_W = 11;
    localparam int PIX_W   = 8;
    localparam int MAPQ_W  = 12;
    localparam int DIM_W   = 11;
    localparam int FRAC_W  = 8;
    localparam int OUT_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_MAPPING_Q  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 2'd2;

    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // Signed compare width: holds coordinates, image sizes and their differences
    localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ?
                             ((MAX_ROWS > 2048) ? MAX_ROWS : 2048) :
                             ((MAX_COLS > 2048) ? MAX_COLS : 2048);
    localparam int CMP_W = $clog2(MAX_DIM) + 2;

    // Largest odd inner size that leaves room for the border ring
    localparam int NMAX = (((MAX_KSIZE - 2) % 2) == 0) ? (MAX_KSIZE - 3) : (MAX_KSIZE - 2);
    localparam int KS_W = $clog2(MAX_KSIZE + 1);

    // Inner weight 512 (shift by 9), ring weight f8
    localparam int WSHIFT = 9;
    localparam int W_MAX  = 512 * NMAX * NMAX + 255 * (4 * NMAX + 4);
    localparam int W_W    = $clog2(W_MAX + 1);
    localparam int D_W    = $clog2(255 * W_MAX + 1);
    localparam int S_W    = D_W;
    localparam int PROD_W = PIX_W + WSHIFT;

    // Quotient never exceeds 65536, so one bit above the output width
    localparam int Q_W     = OUT_W + 1;
    localparam int NUM_W   = S_W + Q_W;
    localparam int DCNT_W  = $clog2(Q_W + 1);

endpackage

// ===== design/weighted_window_brightness_sampler.sv =====
// Channel | Direction | Handshake            | Payload
// s_      | in        | s_tvalid / s_tready  | tdata: row, col, pixel; tuser: command
// m_      | out       | m_tvalid / m_tready  | tdata: brightness; tuser: edge flag
// cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A pixel write leaves the block idle; the next word is taken the cycle after.
// A sample reads the image store once per window pixel (ksz*ksz pixels, ksz =
// inner size + 2, at most 15), then runs a 17-step restoring divider.
// An edge sample skips the scan and the divider. Reset (aresetn low, synchronous)
// restores control and config registers; the image store is undefined until written.
// A result waiting on m_tready does not stop pixel writes; the next sample
// holds in its final cycle until the output register is free.
module weighted_window_brightness_sampler
    import wwbs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [10:0] row_coord, [21:11] col_coord,
                                             // [29:22] pixel_value, [31:30] zero
    input  logic                  s_tuser,   // [0] command

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [15:0] brightness
    output logic                  m_tuser,   // [0] edge_skipped

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_PREP  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam int CMD_WRITE = 0;

    logic [2:0]              state_reg, state_next;
    logic [MAPQ_W-1:0]       mapping_q_reg;
    logic [DIM_W-1:0]        image_rows_reg, image_cols_reg;

    logic [KS_W-1:0]         ksz_reg, ksz_next;
    logic [FRAC_W-1:0]       f8_reg, f8_next;
    logic [ROW_W-1:0]        base_r_reg, base_r_next;
    logic [COL_W-1:0]        base_c_reg, base_c_next;
    logic [KS_W-1:0]         dy_reg, dy_next, dx_reg, dx_next;
    logic                    skip_reg, skip_next;
    logic [W_W-1:0]          w_reg, w_next;
    logic [D_W-1:0]          d_reg, d_next;
    logic [S_W-1:0]          acc_reg, acc_next;
    logic [D_W-1:0]          rem_reg, rem_next;
    logic [Q_W-1:0]          qr_reg, qr_next;
    logic [DCNT_W-1:0]       dcnt_reg, dcnt_next;

    logic                    rd_vld_reg, ring_d_reg;
    logic [PIX_W-1:0]        rd_data_reg;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]        bright_reg, bright_next;
    logic                    edge_reg, edge_next;

    logic [PIX_W-1:0]        mem [MEM_DEPTH];

    // Decoded input word
    logic [COORD_W-1:0]      in_row, in_col;
    logic [PIX_W-1:0]        in_pix;
    logic signed [CMP_W-1:0] row_s, col_s, rows_s, cols_s, rad_s;

    // Window geometry from the mapping register
    logic [5:0]              n_raw, n_odd, n_clip;
    logic [KS_W-1:0]         n_cur, ksz_cur, rad_cur;
    logic [2*KS_W-1:0]       nn;
    logic [KS_W+2:0]         ring_cnt;
    logic                    skip_cur;

    logic                    accept_in, wr_in_range, mem_we;
    logic [ADDR_W-1:0]       wr_addr, rd_addr;
    logic                    scan_last_col, scan_last, ring_cur;
    logic [PROD_W-1:0]       prod;
    logic [NUM_W-1:0]        num;
    logic [D_W:0]            trial;
    logic                    out_load;

    assign in_row = s_tdata[COORD_W-1:0];
    assign in_col = s_tdata[2*COORD_W-1:COORD_W];
    assign in_pix = s_tdata[2*COORD_W+PIX_W-1:2*COORD_W];

    assign row_s  = CMP_W'($signed(in_row));
    assign col_s  = CMP_W'($signed(in_col));
    assign rows_s = (32'(image_rows_reg) < MAX_ROWS) ? $signed(CMP_W'(image_rows_reg))
                                                     : $signed(CMP_W'(MAX_ROWS));
    assign cols_s = (32'(image_cols_reg) < MAX_COLS) ? $signed(CMP_W'(image_cols_reg))
                                                     : $signed(CMP_W'(MAX_COLS));

    always_comb begin
        n_raw  = 6'(mapping_q_reg[MAPQ_W-1:FRAC_W]);
        n_odd  = (n_raw == 6'd0) ? 6'd1 : (n_raw[0] ? n_raw : n_raw - 6'd1);
        n_clip = (n_odd > 6'(NMAX)) ? 6'(NMAX) : n_odd;
        n_cur  = KS_W'(n_clip);
        ksz_cur = n_cur + KS_W'(2);
        rad_cur = KS_W'((n_clip + 6'd1) >> 1);
        nn = (2*KS_W)'(n_cur) * (2*KS_W)'(n_cur);
        ring_cnt = ((KS_W+3)'(n_cur) + (KS_W+3)'(1)) << 2;
    end

    assign rad_s    = $signed(CMP_W'(rad_cur));
    assign skip_cur = (row_s < rad_s) || (col_s < rad_s) ||
                      (row_s >= rows_s - rad_s) || (col_s >= cols_s - rad_s);

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept_in = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign wr_in_range = (row_s >= 0) && (row_s < $signed(CMP_W'(MAX_ROWS))) &&
                         (col_s >= 0) && (col_s < $signed(CMP_W'(MAX_COLS)));
    assign mem_we  = accept_in && (s_tuser == 1'(CMD_WRITE)) && wr_in_range;
    assign wr_addr = ADDR_W'(row_s) * ADDR_W'(MAX_COLS) + ADDR_W'(col_s);
    assign rd_addr = (ADDR_W'(base_r_reg) + ADDR_W'(dy_reg)) * ADDR_W'(MAX_COLS) +
                     ADDR_W'(base_c_reg) + ADDR_W'(dx_reg);

    assign scan_last_col = (dx_reg == ksz_reg - KS_W'(1));
    assign scan_last     = scan_last_col && (dy_reg == ksz_reg - KS_W'(1));
    assign ring_cur      = (dy_reg == '0) || (dx_reg == '0) ||
                           (dy_reg == ksz_reg - KS_W'(1)) || scan_last_col;

    assign prod  = ring_d_reg ? PROD_W'(rd_data_reg * f8_reg)
                              : PROD_W'({rd_data_reg, {WSHIFT{1'b0}}});
    // Dividend is sum * 2^16 plus half the divisor for rounding
    assign num   = NUM_W'({acc_reg, {OUT_W{1'b0}}}) + NUM_W'(d_reg >> 1);
    assign trial = {rem_reg, qr_reg[Q_W-1]};

    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next  = state_reg;
        ksz_next    = ksz_reg;
        f8_next     = f8_reg;
        base_r_next = base_r_reg;
        base_c_next = base_c_reg;
        dy_next     = dy_reg;
        dx_next     = dx_reg;
        skip_next   = skip_reg;
        w_next      = w_reg;
        d_next      = d_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        qr_next     = qr_reg;
        dcnt_next   = dcnt_reg;

        if (rd_vld_reg) begin
            acc_next = acc_reg + S_W'(prod);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept_in && (s_tuser != 1'(CMD_WRITE))) begin
                    ksz_next    = ksz_cur;
                    f8_next     = mapping_q_reg[FRAC_W-1:0];
                    base_r_next = ROW_W'(row_s - rad_s);
                    base_c_next = COL_W'(col_s - rad_s);
                    dy_next     = '0;
                    dx_next     = '0;
                    skip_next   = skip_cur;
                    w_next      = W_W'({nn, {WSHIFT{1'b0}}}) +
                                  W_W'(mapping_q_reg[FRAC_W-1:0] * ring_cnt);
                    acc_next    = '0;
                    state_next  = skip_cur ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Advance across the row, then down
                if (scan_last_col) begin
                    dx_next = '0;
                    dy_next = dy_reg + KS_W'(1);
                end else begin
                    dx_next = dx_reg + KS_W'(1);
                end
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                d_next     = D_W'({w_reg, 8'd0}) - D_W'(w_reg);
                state_next = ST_PREP;
            end
            ST_PREP: begin
                rem_next   = D_W'(num >> Q_W);
                qr_next    = num[Q_W-1:0];
                dcnt_next  = DCNT_W'(Q_W);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (trial >= {1'b0, d_reg}) begin
                    rem_next = D_W'(trial - {1'b0, d_reg});
                    qr_next  = {qr_reg[Q_W-2:0], 1'b1};
                end else begin
                    rem_next = D_W'(trial);
                    qr_next  = {qr_reg[Q_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        bright_next   = bright_reg;
        edge_next     = edge_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            edge_next     = skip_reg;
            if (skip_reg) begin
                bright_next = '0;
            end else if (qr_reg[Q_W-1]) begin
                bright_next = '1;
            end else begin
                bright_next = qr_reg[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mapping_q_reg  <= MAPQ_W'(768);
            image_rows_reg <= DIM_W'(1024);
            image_cols_reg <= DIM_W'(1024);
            rd_vld_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            dcnt_reg       <= '0;
        end else begin
            state_reg    <= state_next;
            rd_vld_reg   <= (state_reg == ST_SCAN);
            m_tvalid_reg <= m_tvalid_next;
            dcnt_reg     <= dcnt_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_MAPPING_Q:  mapping_q_reg  <= cfg_data[MAPQ_W-1:0];
                    REG_IMAGE_ROWS: image_rows_reg <= cfg_data[DIM_W-1:0];
                    REG_IMAGE_COLS: image_cols_reg <= cfg_data[DIM_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        ksz_reg    <= ksz_next;
        f8_reg     <= f8_next;
        base_r_reg <= base_r_next;
        base_c_reg <= base_c_next;
        dy_reg     <= dy_next;
        dx_reg     <= dx_next;
        skip_reg   <= skip_next;
        w_reg      <= w_next;
        d_reg      <= d_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        qr_reg     <= qr_next;
        ring_d_reg <= ring_cur;
        bright_reg <= bright_next;
        edge_reg   <= edge_next;
    end

    // Image store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= in_pix;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = bright_reg;
    assign m_tuser  = edge_reg;

    a_edge_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("edge result carries nonzero brightness");

    a_read_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("store read data arrives outside the window scan");

    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV && dcnt_reg == DCNT_W'(1) |=> state_reg == ST_DONE)
        else $error("divider did not finish after its last step");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("pending result dropped");

endmodule

// ===== test/wwbs_tb_pkg.sv =====
`timescale 1ns / 1ps
package wwbs_tb_pkg;

    // Command carried in s_tuser
    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_e;

endpackage

// ===== test/wwbs_brightness_checker.sv =====
`timescale 1ns / 1ps
module wwbs_brightness_checker
    import wwbs_pkg::*;
    import wwbs_tb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [31:0]           s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [15:0]           m_tdata,
    input  logic                  m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    pending_samples
);

    typedef struct packed {
        logic [OUT_W-1:0] brightness;
        logic             edge_skipped;
    } sample_t;

    bit   [PIX_W-1:0]  image_mem [MAX_ROWS*MAX_COLS];
    logic [MAPQ_W-1:0] mapping_q  = 12'd768;
    logic [DIM_W-1:0]  image_rows = 11'd1024;
    logic [DIM_W-1:0]  image_cols = 11'd1024;
    sample_t           expected_samples [$];
    sample_t           want;
    int                errors = 0;
    int                row;
    int                col;

    initial begin
        mismatch_count  = 0;
        pending_samples = 0;
    end

    function automatic sample_t predict_sample(int crow, int ccol);
        int              n;
        int              nmax;
        int              side;
        int              rad;
        int              nrows;
        int              ncols;
        int              dy;
        int              dx;
        bit              ring;
        longint unsigned f8;
        longint unsigned acc;
        longint unsigned wsum;
        longint unsigned den;
        longint unsigned q;
        sample_t         res;
        n    = int'(mapping_q[11:8]);
        nmax = MAX_KSIZE - 2;
        if (n == 0) n = 1;
        if (n % 2 == 0) n -= 1;
        if (nmax % 2 == 0) nmax -= 1;
        if (n > nmax) n = nmax;
        side  = n + 2;
        rad   = side / 2;
        nrows = (image_rows > MAX_ROWS) ? MAX_ROWS : int'(image_rows);
        ncols = (image_cols > MAX_COLS) ? MAX_COLS : int'(image_cols);
        f8    = longint'(mapping_q[7:0]);
        res.brightness   = '0;
        res.edge_skipped = 1'b1;
        if (crow < rad || ccol < rad || crow >= nrows - rad || ccol >= ncols - rad) begin
            return res;
        end
        // Inner pixels weigh 512, ring pixels weigh the 8-bit fraction
        acc = 0;
        for (dy = 0; dy < side; dy++) begin
            for (dx = 0; dx < side; dx++) begin
                ring = (dy == 0 || dy == side - 1 || dx == 0 || dx == side - 1);
                acc += longint'(image_mem[(crow - rad + dy) * MAX_COLS + (ccol - rad + dx)])
                       * (ring ? f8 : 64'd512);
            end
        end
        wsum = longint'(512 * n * n) + f8 * longint'(4 * n + 4);
        den  = 64'd255 * wsum;
        q    = (acc * 64'd65536 + den / 2) / den;
        if (q > 64'd65535) q = 64'd65535;
        res.brightness   = q[15:0];
        res.edge_skipped = 1'b0;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            mapping_q  = 12'd768;
            image_rows = 11'd1024;
            image_cols = 11'd1024;
            expected_samples.delete();
        end else begin
            // Retire the result word first; a sample taken at this edge cannot answer yet
            if (m_tvalid && m_tready) begin
                if (expected_samples.size() == 0) begin
                    $error("result word with no sample pending: brightness %0d edge_skipped %0d",
                           m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = expected_samples.pop_front();
                    if (m_tdata !== want.brightness) begin
                        $error("brightness: expected %0d, actual %0d", want.brightness, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== want.edge_skipped) begin
                        $error("edge_skipped: expected %0d, actual %0d",
                               want.edge_skipped, m_tuser);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MAPPING_Q:  mapping_q  = cfg_data[MAPQ_W-1:0];
                    REG_IMAGE_ROWS: image_rows = cfg_data[DIM_W-1:0];
                    REG_IMAGE_COLS: image_cols = cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                row = int'($signed(s_tdata[10:0]));
                col = int'($signed(s_tdata[21:11]));
                if (s_tuser == CMD_SAMPLE) begin
                    expected_samples.push_back(predict_sample(row, col));
                end else if (row >= 0 && row < MAX_ROWS && col >= 0 && col < MAX_COLS) begin
                    image_mem[row * MAX_COLS + col] = s_tdata[29:22];
                end
            end
        end
        mismatch_count  <= errors;
        pending_samples <= expected_samples.size();
    end

endmodule

// ===== test/tb_weighted_window_brightness_sampler.sv =====
`timescale 1ns / 1ps
module tb_weighted_window_brightness_sampler;
    import wwbs_pkg::*;
    import wwbs_tb_pkg::*;

    // Fully written patches: one at the image origin, one at the far corner
    localparam int AREA_A_ORG    = 0;
    localparam int AREA_A_SIDE   = 15;
    localparam int AREA_B_ORG    = 1015;
    localparam int AREA_B_SIDE   = 9;
    localparam int SETTLE_CYCLES = 300;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 45;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int                mismatch_count;
    int                pending_samples;
    int                send_idle = 0;
    int                recv_idle = 0;
    logic [MAPQ_W-1:0] cur_mapq  = 12'd768;
    logic [DIM_W-1:0]  cur_rows  = 11'd1024;
    logic [DIM_W-1:0]  cur_cols  = 11'd1024;
    bit                pix_known [MAX_ROWS*MAX_COLS];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    weighted_window_brightness_sampler u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wwbs_brightness_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_samples (pending_samples)
    );

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    function automatic int rand_coord();
        logic [10:0] v;
        v = 11'($urandom);
        return int'($signed(v));
    endfunction

    function automatic int window_radius();
        int n;
        int nmax;
        n    = int'(cur_mapq[11:8]);
        nmax = MAX_KSIZE - 2;
        if (n == 0) n = 1;
        if (n % 2 == 0) n -= 1;
        if (nmax % 2 == 0) nmax -= 1;
        if (n > nmax) n = nmax;
        return (n + 2) / 2;
    endfunction

    // True when the sample is skipped at the edge or reads only written pixels
    function automatic bit window_safe(int crow, int ccol);
        int rad;
        int nrows;
        int ncols;
        int r;
        int c;
        rad   = window_radius();
        nrows = (cur_rows > MAX_ROWS) ? MAX_ROWS : int'(cur_rows);
        ncols = (cur_cols > MAX_COLS) ? MAX_COLS : int'(cur_cols);
        if (crow < rad || ccol < rad || crow >= nrows - rad || ccol >= ncols - rad) return 1'b1;
        for (r = crow - rad; r <= crow + rad; r++) begin
            for (c = ccol - rad; c <= ccol + rad; c++) begin
                if (!pix_known[r * MAX_COLS + c]) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 7))
            0, 1, 2: return 11'd1024;
            3:       return 11'($urandom_range(1025, 2047));
            4:       return 11'($urandom_range(1, 1024));
            5:       return 11'($urandom_range(AREA_A_SIDE - 6, AREA_A_SIDE + 2));
            6:       return 11'($urandom_range(0, 1));
            default: return 11'(AREA_B_ORG + $urandom_range(2, AREA_B_SIDE));
        endcase
    endfunction

    task automatic send_word(cmd_e cmd, int row, int col, int pix);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, pix[7:0], col[10:0], row[10:0]};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_WRITE && row >= 0 && row < MAX_ROWS && col >= 0 && col < MAX_COLS) begin
            pix_known[row * MAX_COLS + col] = 1'b1;
        end
    endtask

    // Hold the sender until every sample word has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_samples != 0);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic reconfigure(logic [MAPQ_W-1:0] mapq, logic [DIM_W-1:0] rows,
                               logic [DIM_W-1:0] cols);
        drain_results();
        // A trailing pixel write may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_write(REG_MAPPING_Q, mapq);
        cfg_write(REG_IMAGE_ROWS, {1'b0, rows});
        cfg_write(REG_IMAGE_COLS, {1'b0, cols});
        cur_mapq = mapq;
        cur_rows = rows;
        cur_cols = cols;
    endtask

    initial begin
        int               row;
        int               col;
        int               pick;
        int               tries;
        int               pix;
        int               ph;
        int               i;
        int               rad;
        int               span;
        logic [MAPQ_W-1:0] mapq;

        send_idle = 34;
        recv_idle <= 53;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: 3x3 window at the origin, smallest inner size, full ring weight
        reconfigure(12'h1FF, 11'd1024, 11'd1024);
        for (row = 0; row < 3; row++) begin
            for (col = 0; col < 3; col++) begin
                send_word(CMD_WRITE, row, col, 255);
            end
        end
        send_word(CMD_SAMPLE, 1, 1, 0);
        send_word(CMD_WRITE, 1, 1, 0);
        send_word(CMD_SAMPLE, 1, 1, 255);
        send_word(CMD_SAMPLE, 0, 1, 0);
        send_word(CMD_SAMPLE, 1023, 1023, 0);
        send_word(CMD_SAMPLE, -1024, -1024, 0);
        send_word(CMD_SAMPLE, 1023, -1, 0);
        // Writes outside the store get dropped
        send_word(CMD_WRITE, -1, 0, 255);
        send_word(CMD_WRITE, 0, -1024, 255);
        send_word(CMD_WRITE, -1024, 1023, 255);
        send_word(CMD_WRITE, 1023, 1023, 0);
        // Integer part of zero behaves as one
        reconfigure(12'h0FF, 11'd1024, 11'd1024);
        send_word(CMD_SAMPLE, 1, 1, 0);
        // Oversize window clamps, then skips at the origin
        reconfigure(12'hFFF, 11'd1024, 11'd1024);
        send_word(CMD_SAMPLE, 1, 1, 0);
        // Zero ring weight
        reconfigure(12'h100, 11'd1024, 11'd1024);
        send_word(CMD_SAMPLE, 1, 1, 0);
        // Largest inner size and ring weight with an empty image
        reconfigure(12'hDFF, 11'd0, 11'd2047);
        send_word(CMD_SAMPLE, 1, 1, 0);
        // Smallest image that still fits a window
        reconfigure(12'h1FF, 11'd3, 11'd3);
        send_word(CMD_SAMPLE, 1, 1, 0);
        send_word(CMD_SAMPLE, 2, 1, 0);

        for (row = 0; row < AREA_A_SIDE; row++) begin
            for (col = 0; col < AREA_A_SIDE; col++) begin
                send_word(CMD_WRITE, AREA_A_ORG + row, AREA_A_ORG + col, $urandom_range(0, 255));
            end
        end
        for (row = 0; row < AREA_B_SIDE; row++) begin
            for (col = 0; col < AREA_B_SIDE; col++) begin
                send_word(CMD_WRITE, AREA_B_ORG + row, AREA_B_ORG + col, $urandom_range(0, 255));
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph == 3) begin
                send_idle = 53;
                recv_idle <= 34;
            end else if (ph == 6) begin
                send_idle = 0;
                recv_idle <= 0;
            end
            case ($urandom_range(0, 7))
                0:       mapq = 12'($urandom_range(0, 4095));
                1:       mapq = 12'hDFF;
                2:       mapq = 12'h100;
                default: mapq = 12'($urandom_range(1, 5) * 256 + $urandom_range(0, 255));
            endcase
            if (ph == 2) begin
                reconfigure(12'hDFF, 11'd1024, 11'd1024);
            end else begin
                reconfigure(mapq, pick_dim(), pick_dim());
            end
            rad = window_radius();
            for (i = 0; i < PHASE_ITEMS; i++) begin
                pick = $urandom_range(0, 99);
                pix  = ($urandom_range(0, 7) == 0) ? 255 * $urandom_range(0, 1)
                                                   : $urandom_range(0, 255);
                if (pick < 50) begin
                    tries = 0;
                    do begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3, 4, 5: begin
                                span = AREA_A_SIDE - 2 * rad;
                                row  = AREA_A_ORG + rad + $urandom_range(0, (span > 0) ? span - 1 : 0)
                                       + $urandom_range(0, 2) - 1;
                                col  = AREA_A_ORG + rad + $urandom_range(0, (span > 0) ? span - 1 : 0)
                                       + $urandom_range(0, 2) - 1;
                            end
                            6, 7: begin
                                span = AREA_B_SIDE - 2 * rad;
                                row  = AREA_B_ORG + rad + $urandom_range(0, (span > 0) ? span - 1 : 0)
                                       + $urandom_range(0, 2) - 1;
                                col  = AREA_B_ORG + rad + $urandom_range(0, (span > 0) ? span - 1 : 0)
                                       + $urandom_range(0, 2) - 1;
                            end
                            default: begin
                                row = rand_coord();
                                col = rand_coord();
                            end
                        endcase
                        tries++;
                    end while (!window_safe(row, col) && tries < 20);
                    // Fall back to a centre above the image
                    if (!window_safe(row, col)) row = -1;
                    send_word(CMD_SAMPLE, row, col, $urandom_range(0, 255));
                end else if (pick < 85) begin
                    if ($urandom_range(0, 3) != 0) begin
                        send_word(CMD_WRITE, AREA_A_ORG + $urandom_range(0, AREA_A_SIDE - 1),
                                  AREA_A_ORG + $urandom_range(0, AREA_A_SIDE - 1), pix);
                    end else begin
                        send_word(CMD_WRITE, AREA_B_ORG + $urandom_range(0, AREA_B_SIDE - 1),
                                  AREA_B_ORG + $urandom_range(0, AREA_B_SIDE - 1), pix);
                    end
                end else begin
                    send_word(CMD_WRITE, rand_coord(), rand_coord(), pix);
                end
                if ($urandom_range(0, 59) == 0) drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_samples == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #(40_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule
